// File: design/websocket_frame_unmasker_unit_defines.svh
// assertion macros for the websocket frame unmasker
`ifndef WEBSOCKET_FRAME_UNMASKER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_UNMASKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// cond must never hold at a clock edge outside reset
`define WSFU_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("wsfu assertion failed: forbidden condition");

// ante at an edge requires cons at the same edge
`define WSFU_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsfu assertion failed: implication violated");

`else

`define WSFU_ASSERT_NEVER(label, cond)
`define WSFU_ASSERT_IMPLY(label, ante, cons)

`endif

`endif

// File: design/wsfu_pkg.sv
package wsfu_pkg;

  localparam logic [3:0] OPCODE_TEXT  = 4'h1;
  localparam logic [3:0] OPCODE_CLOSE = 4'h8;

  localparam logic [1:0] KIND_DATA        = 2'd0;
  localparam logic [1:0] KIND_CLOSE       = 2'd1;
  localparam logic [1:0] KIND_UNSUPPORTED = 2'd2;

  localparam logic [7:0] POS_LENGTH    = 8'd1;
  localparam logic [7:0] PAYLOAD_START = 8'd6;
  localparam logic [6:0] LEN_EXT_MIN   = 7'd126;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_start;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       last;
  } out_t;

  // classified work handed from front to back
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] mask;
    logic       last;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

// File: design/wsfu_front.sv
module wsfu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  wsfu_pkg::in_t in_data,
  output logic          push,
  output wsfu_pkg::job_t job
);
  import wsfu_pkg::*;

  logic [7:0]  pos_r, pos_nxt;
  logic        active_r, active_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [31:0] key_r, key_nxt;

  logic [7:0] idx;
  logic [7:0] idx_plus1;
  logic [3:0] opcode;
  logic [6:0] len_in;
  logic [7:0] mask_sel;

  assign opcode    = in_data.data_byte[3:0];
  assign len_in    = in_data.data_byte[6:0];
  assign idx       = pos_r - PAYLOAD_START;
  assign idx_plus1 = idx + 8'd1;

  always_comb begin
    case (idx[1:0])
      2'd0:    mask_sel = key_r[31:24];
      2'd1:    mask_sel = key_r[23:16];
      2'd2:    mask_sel = key_r[15:8];
      default: mask_sel = key_r[7:0];
    endcase
  end

  always_comb begin
    pos_nxt    = pos_r;
    active_nxt = active_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    push       = 1'b0;
    job        = '{kind: KIND_DATA, data: 8'd0, mask: 8'd0, last: 1'b0};
    if (in_fire) begin
      if (in_data.chunk_start) begin
        pos_nxt    = POS_LENGTH;
        active_nxt = (opcode == OPCODE_TEXT);
        len_nxt    = 7'd0;
        key_nxt    = 32'd0;
        if (opcode == OPCODE_CLOSE) begin
          push     = 1'b1;
          job.kind = KIND_CLOSE;
        end
      end else if (active_r) begin
        pos_nxt = pos_r + 8'd1;
        if (pos_r == POS_LENGTH) begin
          len_nxt = len_in;
          if (len_in >= LEN_EXT_MIN) begin
            active_nxt = 1'b0;
            push       = 1'b1;
            job.kind   = KIND_UNSUPPORTED;
          end else if (len_in == 7'd0) begin
            active_nxt = 1'b0;
          end
        end else if (pos_r < PAYLOAD_START) begin
          key_nxt = {key_r[23:0], in_data.data_byte};
        end else begin
          push     = 1'b1;
          job.kind = KIND_DATA;
          job.data = in_data.data_byte;
          job.mask = mask_sel;
          job.last = (idx_plus1 >= {1'b0, len_r});
          if (job.last) begin
            active_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 8'd0;
      active_r <= 1'b0;
      len_r    <= 7'd0;
      key_r    <= 32'd0;
    end else begin
      pos_r    <= pos_nxt;
      active_r <= active_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
    end
  end

endmodule

// File: design/wsfu_queue.sv
`include "websocket_frame_unmasker_unit_defines.svh"

module wsfu_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wsfu_pkg::job_t    push_job,
  input  logic              pop,
  output wsfu_pkg::job_t    head_job,
  output wsfu_pkg::q_stat_t stat
);
  import wsfu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign stat.full      = (count_r == FULL_CNT);
  assign stat.not_empty = (count_r != '0);
  assign head_job       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `WSFU_ASSERT_NEVER(a_no_overflow, push && stat.full && !pop)
  `WSFU_ASSERT_NEVER(a_no_underflow, pop && !stat.not_empty)
  `WSFU_ASSERT_IMPLY(a_count_bound, 1'b1, count_r <= FULL_CNT)

endmodule

// File: design/wsfu_back.sv
`include "websocket_frame_unmasker_unit_defines.svh"

module wsfu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  wsfu_pkg::q_stat_t q_stat,
  input  wsfu_pkg::job_t    head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output wsfu_pkg::out_t    out_data
);
  import wsfu_pkg::*;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;
  out_t result;

  assign pop = q_stat.not_empty && (!out_valid_r || !out_stall);

  always_comb begin
    result.kind         = head_job.kind;
    result.payload_byte = (head_job.kind == KIND_DATA) ? (head_job.data ^ head_job.mask) : 8'd0;
    result.last         = (head_job.kind == KIND_DATA) && head_job.last;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WSFU_ASSERT_IMPLY(a_nondata_zero, out_valid_r && out_data_r.kind != KIND_DATA,
                     out_data_r.payload_byte == 8'd0 && !out_data_r.last)
  `WSFU_ASSERT_NEVER(a_kind_legal, out_valid_r && out_data_r.kind == 2'd3)
  `WSFU_ASSERT_NEVER(a_no_overwrite, pop && out_valid_r && out_stall)

endmodule

// File: design/websocket_frame_unmasker_unit.sv
// channel  direction  handshake              payload
// in_      input      in_valid / in_stall    in_data  (data_byte, chunk_start)
// out_     output     out_valid / out_stall  out_data (kind, payload_byte, last)
//
// one byte accepted per cycle while in_stall is low; a result passes through the queue and then the output register
// the front parser updates frame state on each accepted byte, the queue decouples it from the output register
// in_stall rises only when the queue is full, which takes a stalled output
// rst_n is synchronous, active low, and drops all queued results
module websocket_frame_unmasker_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  wsfu_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output wsfu_pkg::out_t out_data
);
  import wsfu_pkg::*;

  logic    in_fire;
  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head_job;
  q_stat_t q_stat;

  assign in_stall = q_stat.full;
  assign in_fire  = in_valid && !q_stat.full;

  wsfu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .push    (push),
    .job     (push_job)
  );

  wsfu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  wsfu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/unmask_checker.sv
`timescale 1ns / 100ps

module unmask_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  wsfu_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  wsfu_pkg::out_t out_data,
  output int             err_count,
  output int             n_pending,
  output int             n_payload,
  output int             n_close,
  output int             n_unsup
);
  import wsfu_pkg::*;

  logic [7:0]  frame_pos;
  logic        text_active;
  logic [6:0]  frame_len;
  logic [31:0] mask_word;
  out_t        due_q[$];

  task automatic queue_result(input logic [1:0] k, input logic [7:0] b, input logic l);
    out_t r;
    r.kind = k;
    r.payload_byte = b;
    r.last = l;
    due_q.push_back(r);
  endtask

  task automatic follow_byte(input in_t t);
    logic [7:0] pos;
    logic [7:0] idx;
    logic [7:0] key_byte;
    if (t.chunk_start) begin
      frame_pos = 8'd1;
      text_active = 1'b0;
      frame_len = '0;
      mask_word = '0;
      if (t.data_byte[3:0] == OPCODE_CLOSE) begin
        queue_result(KIND_CLOSE, 8'h00, 1'b0);
      end else if (t.data_byte[3:0] == OPCODE_TEXT) begin
        text_active = 1'b1;
      end
    end else if (text_active) begin
      pos = frame_pos;
      frame_pos = frame_pos + 8'd1;
      if (pos == POS_LENGTH) begin
        frame_len = t.data_byte[6:0];
        if (frame_len >= LEN_EXT_MIN) begin
          text_active = 1'b0;
          queue_result(KIND_UNSUPPORTED, 8'h00, 1'b0);
        end else if (frame_len == 7'd0) begin
          text_active = 1'b0;
        end
      end else if (pos < PAYLOAD_START) begin
        mask_word = {mask_word[23:0], t.data_byte};
      end else begin
        idx = pos - PAYLOAD_START;
        case (idx[1:0])
          2'd0: key_byte = mask_word[31:24];
          2'd1: key_byte = mask_word[23:16];
          2'd2: key_byte = mask_word[15:8];
          default: key_byte = mask_word[7:0];
        endcase
        if (32'(idx) + 1 >= 32'(frame_len)) begin
          text_active = 1'b0;
          queue_result(KIND_DATA, t.data_byte ^ key_byte, 1'b1);
        end else begin
          queue_result(KIND_DATA, t.data_byte ^ key_byte, 1'b0);
        end
      end
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (due_q.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("unexpected result: kind %0d byte %02h last %0d",
                 got.kind, got.payload_byte, got.last);
    end else begin
      want = due_q.pop_front();
      if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
          got.last !== want.last) begin
        err_count++;
        if (err_count <= 10)
          $display("mismatch: expected kind %0d byte %02h last %0d, %s %0d byte %02h last %0d",
                   want.kind, want.payload_byte, want.last, "got kind",
                   got.kind, got.payload_byte, got.last);
      end
      case (want.kind)
        KIND_DATA: n_payload++;
        KIND_CLOSE: n_close++;
        default: n_unsup++;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_pos = '0;
      text_active = 1'b0;
      frame_len = '0;
      mask_word = '0;
      due_q.delete();
      err_count = 0;
      n_pending <= 0;
      n_payload = 0;
      n_close = 0;
      n_unsup = 0;
    end else begin
      // input transaction first, its result cannot leave in the same cycle
      if (in_valid && !in_stall)
        follow_byte(in_data);
      if (out_valid && !out_stall)
        check_result(out_data);
      n_pending <= due_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import wsfu_pkg::*;

  localparam logic [3:0] OPCODE_BINARY = 4'h2;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int err_count;
  int n_pending;
  int n_payload;
  int n_close;
  int n_unsup;

  int n_sent = 0;
  bit gappy = 1'b0;
  int stall_left = 0;
  int stall_pick;

  always #5 clk = ~clk;

  websocket_frame_unmasker_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  unmask_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .err_count(err_count),
    .n_pending(n_pending),
    .n_payload(n_payload),
    .n_close  (n_close),
    .n_unsup  (n_unsup)
  );

  // receiver back-pressure: free stretches, short stalls, a few long ones
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(1, 30);
      end else if (stall_pick < 90) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end else begin
      stall_left = stall_left - 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    int pause;
    int pick;
    pause = 0;
    if (gappy) begin
      pick = $urandom_range(0, 99);
      if (pick >= 95)
        pause = $urandom_range(8, 40);
      else if (pick >= 70)
        pause = $urandom_range(1, 3);
    end
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_data <= {b, s};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // hold off the sender until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (n_pending != 0);
    @(posedge clk);
  endtask

  task automatic loose_bytes(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = $urandom;
      send_byte(b, 1'b0);
    end
  endtask

  task automatic text_frame(input int len_req, input bit allow_cut);
    logic [7:0] bytes_q[$];
    logic [7:0] b;
    int len;
    int limit;
    int pick;
    if (len_req >= 0) begin
      len = len_req;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 80)
        len = $urandom_range(0, 12);
      else if (pick < 95)
        len = $urandom_range(13, 125);
      else
        len = $urandom_range(126, 127);
    end
    b = $urandom;
    b[3:0] = OPCODE_TEXT;
    bytes_q.push_back(b);
    b = $urandom;
    b[6:0] = len[6:0];
    bytes_q.push_back(b);
    if (len < LEN_EXT_MIN) begin
      repeat (4 + len) begin
        b = $urandom;
        bytes_q.push_back(b);
      end
    end else begin
      repeat ($urandom_range(0, 4)) begin
        b = $urandom;
        bytes_q.push_back(b);
      end
    end
    limit = bytes_q.size();
    if (allow_cut && $urandom_range(0, 9) == 0)
      limit = $urandom_range(1, limit - 1);
    for (int i = 0; i < limit; i++)
      send_byte(bytes_q[i], i == 0);
    if (limit == bytes_q.size() && $urandom_range(0, 2) == 0)
      loose_bytes($urandom_range(1, 3));
  endtask

  task automatic close_frame();
    logic [7:0] b;
    b = $urandom;
    b[3:0] = OPCODE_CLOSE;
    send_byte(b, 1'b1);
    loose_bytes($urandom_range(0, 3));
  endtask

  task automatic other_frame();
    logic [7:0] b;
    b = $urandom;
    send_byte(b, 1'b1);
    loose_bytes($urandom_range(0, 4));
  endtask

  task automatic noise_bytes();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      b = $urandom;
      send_byte(b, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    int frames;
    int pick;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // bytes before any chunk start
    send_byte(8'hFF, 1'b0);
    // close with a trailing byte
    send_byte({4'h8, OPCODE_CLOSE}, 1'b1);
    send_byte({4'h8, OPCODE_TEXT}, 1'b0);
    // unknown opcode, rest ignored
    send_byte({4'h7, OPCODE_BINARY}, 1'b1);
    send_byte(8'hFF, 1'b0);
    // extended length codes
    send_byte({4'h8, OPCODE_TEXT}, 1'b1);
    send_byte({1'b1, LEN_EXT_MIN}, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte({4'h0, OPCODE_TEXT}, 1'b1);
    send_byte({1'b0, LEN_EXT_MIN + 7'd1}, 1'b0);
    // empty text frame
    send_byte({4'h8, OPCODE_TEXT}, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hAA, 1'b0);
    // five payload bytes, then trailing data
    send_byte({4'h8, OPCODE_TEXT}, 1'b1);
    send_byte(8'h85, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h33, 1'b0);
    // frame cut short by the next chunk
    send_byte({4'h8, OPCODE_TEXT}, 1'b1);
    send_byte(8'h83, 1'b0);
    text_frame(125, 1'b0);
    drain_results();

    frames = 0;
    while (n_sent < 1600) begin
      gappy = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 60)
        text_frame(-1, 1'b1);
      else if (pick < 70)
        close_frame();
      else if (pick < 80)
        other_frame();
      else
        noise_bytes();
      frames++;
      if (frames % 150 == 0)
        drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);
    @(negedge clk);
    $display("sent %0d bytes in %0d random frames plus directed cases", n_sent, frames);
    $display("checked %0d payload bytes, %0d close and %0d unsupported-length results",
             n_payload, n_close, n_unsup);
    if (err_count == 0 && n_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: websocket_frame_unmasker_unit.f
+incdir+design
design/wsfu_pkg.sv
design/wsfu_front.sv
design/wsfu_queue.sv
design/wsfu_back.sv
design/websocket_frame_unmasker_unit.sv
tb/unmask_checker.sv
tb/tb_top.sv
